### hw/rtl/eac_pkg.sv
// Shared constants, types and the arctangent table of the Euler angle to axes block.
package eac_pkg;

  localparam int ANGLE_W = 17;
  localparam int AXIS_W  = 16;
  localparam int Z_W     = 32;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ANGLE_W-1:0] FULL_TURN    = 17'sd46080;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 17'sd11520;

  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam int     OUT_ONE  = 16384;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [Z_W-1:0]     zang_t;

  // Arctangent of 2^-i in units of 2^-23 degree.
  function automatic zang_t atan_deg23(input int i);
    zang_t r;
    case (i)
      0:  r = 32'sd377487360;
      1:  r = 32'sd222843801;
      2:  r = 32'sd117744544;
      3:  r = 32'sd59768969;
      4:  r = 32'sd30000467;
      5:  r = 32'sd15014858;
      6:  r = 32'sd7509261;
      7:  r = 32'sd3754860;
      8:  r = 32'sd1877459;
      9:  r = 32'sd938733;
      10: r = 32'sd469367;
      11: r = 32'sd234683;
      12: r = 32'sd117342;
      13: r = 32'sd58671;
      14: r = 32'sd29335;
      15: r = 32'sd14668;
      16: r = 32'sd7334;
      17: r = 32'sd3667;
      18: r = 32'sd1833;
      19: r = 32'sd917;
      20: r = 32'sd458;
      21: r = 32'sd229;
      22: r = 32'sd115;
      23: r = 32'sd57;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/eac_angles_if.sv
// Input channel carrying one triple of Euler angles.
interface eac_angles_if;
  logic valid;
  logic ready;
  logic signed [16:0] angle_x;
  logic signed [16:0] angle_y;
  logic signed [16:0] angle_z;
  modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
  modport sink (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

### hw/rtl/eac_axes_if.sv
// Output channel carrying the three axis vectors.
interface eac_axes_if;
  logic valid;
  logic ready;
  logic signed [15:0] side_x;
  logic signed [15:0] side_y;
  logic signed [15:0] side_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic signed [15:0] forward_x;
  logic signed [15:0] forward_y;
  logic signed [15:0] forward_z;
  modport source (output valid, output side_x, output side_y, output side_z, output up_x,
                  output up_y, output up_z, output forward_x, output forward_y,
                  output forward_z, input ready);
  modport sink (input valid, input side_x, input side_y, input side_z, input up_x,
                input up_y, input up_z, input forward_x, input forward_y,
                input forward_z, output ready);
endinterface

### hw/rtl/euler_angles_to_axes_core.sv
// Top level: Euler angles (Y*X*Z order) to side, up and forward axis vectors.
// Pipeline stages: one angle-fold stage, one stage per CORDIC
// iteration, a clamp stage, two product stages, a sum stage and an output rounding stage.
// Throughput is one item per cycle; the whole pipeline advances together and holds
// when the final result is not taken.
// Reset (rst, synchronous) clears only the valid bits; data registers are not reset.
module euler_angles_to_axes_core #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int FRACTION_BITS   = 14
) (
  input logic clk,
  input logic rst,
  eac_angles_if.sink angles,
  eac_axes_if.source axes
);
  import eac_pkg::*;

  localparam int VW  = FRACTION_BITS + 2;   // sine, cosine and products, within +-1.0
  localparam int SW  = FRACTION_BITS + 3;   // sums of two products
  localparam int PW  = 2 * VW;
  localparam int TW  = SW + 16;
  localparam int LAT = TRIG_ITERATIONS + 6;
  localparam int OSH = (FRACTION_BITS > 14) ? FRACTION_BITS - 14 : 0;
  localparam int USH = (FRACTION_BITS < 14) ? 14 - FRACTION_BITS : 0;
  localparam longint OHALF = (64'sd1 << OSH) >>> 1;
  localparam logic signed [PW-1:0] PHALF = PW'(64'sd1 <<< (FRACTION_BITS - 1));

  // The pipeline moves whenever the output register is empty or being drained.
  logic en;
  logic [LAT-1:0] vld;

  assign en           = !vld[LAT-1] || axes.ready;
  assign angles.ready = en;
  assign axes.valid   = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], angles.valid};
    end
  end

  // Rounded fixed-point product, half an LSB added then floor shift.
  function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    p = (p + PHALF) >>> FRACTION_BITS;
    return p[VW-1:0];
  endfunction

  // Convert to Q1.14 with rounding and saturate to +-1.0.
  function automatic axis_t to_out(input logic signed [SW-1:0] v);
    logic signed [TW-1:0] t;
    t = TW'(v);
    if (FRACTION_BITS > 14) begin
      t = (t + TW'(OHALF)) >>> OSH;
    end else if (FRACTION_BITS < 14) begin
      t = t <<< USH;
    end
    if (t > TW'(OUT_ONE))  t = TW'(OUT_ONE);
    if (t < -TW'(OUT_ONE)) t = -TW'(OUT_ONE);
    return t[AXIS_W-1:0];
  endfunction

  // Three parallel sine/cosine pipelines, one per angle.
  logic signed [VW-1:0] sx, cx, sy, cy, sz, cz;

  eac_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .FRACTION_BITS(FRACTION_BITS)) u_sc_x (
    .clk(clk), .en(en), .angle(angles.angle_x), .sin_q(sx), .cos_q(cx));
  eac_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .FRACTION_BITS(FRACTION_BITS)) u_sc_y (
    .clk(clk), .en(en), .angle(angles.angle_y), .sin_q(sy), .cos_q(cy));
  eac_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .FRACTION_BITS(FRACTION_BITS)) u_sc_z (
    .clk(clk), .en(en), .angle(angles.angle_z), .sin_q(sz), .cos_q(cz));

  // First product stage: all two-factor products, plus the pitch terms sy*sx and cy*sx.
  logic signed [VW-1:0] p_sysx, p_cysx, p_cycz, p_cysz, p_sycx, p_cxsz, p_cxcz;
  logic signed [VW-1:0] p_sycz, p_sysz, p_cycx, p_sx, p_sz, p_cz;

  always_ff @(posedge clk) begin
    if (en) begin
      p_sysx <= fmul(sy, sx);
      p_cysx <= fmul(cy, sx);
      p_cycz <= fmul(cy, cz);
      p_cysz <= fmul(cy, sz);
      p_sycx <= fmul(sy, cx);
      p_cxsz <= fmul(cx, sz);
      p_cxcz <= fmul(cx, cz);
      p_sycz <= fmul(sy, cz);
      p_sysz <= fmul(sy, sz);
      p_cycx <= fmul(cy, cx);
      p_sx   <= sx;
      p_sz   <= sz;
      p_cz   <= cz;
    end
  end

  // Second product stage: the three-factor terms; two-factor products ride along.
  logic signed [VW-1:0] q_sysxsz, q_sysxcz, q_cysxsz, q_cysxcz;
  logic signed [VW-1:0] q_cycz, q_cysz, q_sycx, q_cxsz, q_cxcz, q_sycz, q_sysz, q_cycx, q_sx;

  always_ff @(posedge clk) begin
    if (en) begin
      q_sysxsz <= fmul(p_sysx, p_sz);
      q_sysxcz <= fmul(p_sysx, p_cz);
      q_cysxsz <= fmul(p_cysx, p_sz);
      q_cysxcz <= fmul(p_cysx, p_cz);
      q_cycz   <= p_cycz;
      q_cysz   <= p_cysz;
      q_sycx   <= p_sycx;
      q_cxsz   <= p_cxsz;
      q_cxcz   <= p_cxcz;
      q_sycz   <= p_sycz;
      q_sysz   <= p_sysz;
      q_cycx   <= p_cycx;
      q_sx     <= p_sx;
    end
  end

  // Sum stage: each matrix entry at full internal precision.
  logic signed [SW-1:0] s_side_x, s_side_y, s_side_z, s_up_x, s_up_y, s_up_z;
  logic signed [SW-1:0] s_fwd_x, s_fwd_y, s_fwd_z;

  always_ff @(posedge clk) begin
    if (en) begin
      s_side_x <= SW'(q_cycz) - SW'(q_sysxsz);
      s_side_y <= SW'(q_cysz) + SW'(q_sysxcz);
      s_side_z <= -SW'(q_sycx);
      s_up_x   <= -SW'(q_cxsz);
      s_up_y   <= SW'(q_cxcz);
      s_up_z   <= SW'(q_sx);
      s_fwd_x  <= SW'(q_sycz) + SW'(q_cysxsz);
      s_fwd_y  <= SW'(q_sysz) - SW'(q_cysxcz);
      s_fwd_z  <= SW'(q_cycx);
    end
  end

  // Output register: rounding to Q1.14 and saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      axes.side_x    <= to_out(s_side_x);
      axes.side_y    <= to_out(s_side_y);
      axes.side_z    <= to_out(s_side_z);
      axes.up_x      <= to_out(s_up_x);
      axes.up_y      <= to_out(s_up_y);
      axes.up_z      <= to_out(s_up_z);
      axes.forward_x <= to_out(s_fwd_x);
      axes.forward_y <= to_out(s_fwd_y);
      axes.forward_z <= to_out(s_fwd_z);
    end
  end

  // An accepted item always enters the first valid stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    angles.valid && angles.ready |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  // While stalled, no item moves, appears or disappears.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits changed during a stall");

  // Saturation keeps delivered components within +-1.0; checked here on up_z and side_x.
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    axes.valid |-> ($signed(axes.up_z) <= 16'sd16384 && $signed(axes.up_z) >= -16'sd16384 &&
                    $signed(axes.side_x) <= 16'sd16384 && $signed(axes.side_x) >= -16'sd16384))
    else $error("output component beyond saturation bound");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !axes.valid)
    else $error("output valid after reset");

endmodule

### hw/rtl/eac_sincos.sv
// Pipelined angle reduction and CORDIC producing sine and cosine of one angle.
module eac_sincos #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                        clk,
  input  logic                        en,
  input  eac_pkg::angle_t             angle,
  output logic signed [FRACTION_BITS+1:0] sin_q,
  output logic signed [FRACTION_BITS+1:0] cos_q
);
  import eac_pkg::*;

  localparam int XW = FRACTION_BITS + 3;
  localparam int KSH = 30 - FRACTION_BITS;
  localparam longint KHALF = (64'sd1 << KSH) >>> 1;
  localparam longint KVAL = (GAIN_Q30 + KHALF) >>> KSH;
  localparam logic signed [XW-1:0] ONE = XW'(64'sd1 <<< FRACTION_BITS);

  angle_t wrapped;
  angle_t folded;
  logic   fold_neg;

  // Wrap into [-180, 180) then fold into [-90, 90].
  always_comb begin
    wrapped = angle;
    if (angle >= HALF_TURN) begin
      wrapped = angle - FULL_TURN;
    end else if (angle < -HALF_TURN) begin
      wrapped = angle + FULL_TURN;
    end
    folded   = wrapped;
    fold_neg = 1'b0;
    if (wrapped > QUARTER_TURN) begin
      folded   = wrapped - HALF_TURN;
      fold_neg = 1'b1;
    end else if (wrapped < -QUARTER_TURN) begin
      folded   = wrapped + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  logic signed [XW-1:0] x [0:TRIG_ITERATIONS];
  logic signed [XW-1:0] y [0:TRIG_ITERATIONS];
  zang_t                z [0:TRIG_ITERATIONS];
  logic                 neg [0:TRIG_ITERATIONS];

  assign x[0] = XW'(KVAL);
  assign y[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      z[0]   <= Z_W'(folded) <<< 16;
      neg[0] <= fold_neg;
    end
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (!z[i][Z_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_deg23(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_deg23(i);
        end
      end
    end
  end

  logic signed [XW-1:0] xc, yc;

  always_comb begin
    xc = x[TRIG_ITERATIONS];
    yc = y[TRIG_ITERATIONS];
    if (xc > ONE)  xc = ONE;
    if (xc < -ONE) xc = -ONE;
    if (yc > ONE)  yc = ONE;
    if (yc < -ONE) yc = -ONE;
    if (neg[TRIG_ITERATIONS]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= yc[XW-2:0];
      cos_q <= xc[XW-2:0];
    end
  end

endmodule

### dv/eac_tb_if.sv
`timescale 1ns / 1ps
// Testbench types for the test of the Euler angle to axes core.
package eac_tb_types;
  typedef struct {
    logic signed [15:0] v [9];
  } axes_t;
endpackage

### dv/euler_angles_to_axes_core_test.sv
`timescale 1ns / 1ps
// Self-checking test of the Euler angle to axis vector core against a bit-exact predictor.
module euler_angles_to_axes_core_test;
  import eac_pkg::*;
  import eac_tb_types::*;

  localparam int TRIG_ITERATIONS = 16;
  localparam int FRACTION_BITS = 14;
  localparam int LATENCY = TRIG_ITERATIONS + 6;

  // Floor shift and round-half-up shift, as the datapath uses them.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_shift(a * b, FRACTION_BITS);
  endfunction

  // Wraps, folds and runs the CORDIC for one angle.
  function automatic void trig_of(logic [16:0] raw, output longint s, output longint c);
    longint one, a, x, y, z, dx, dy;
    bit flip;
    one = longint'(1) << FRACTION_BITS;
    a = longint'($signed(raw)) % FULL_TURN;
    flip = 0;
    if (a < 0) a += FULL_TURN;
    if (a >= HALF_TURN) a -= FULL_TURN;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1;
    end
    x = round_shift(GAIN_Q30, 30 - FRACTION_BITS);
    y = 0;
    z = a * 65536;
    for (int i = 0; i < TRIG_ITERATIONS && i < TABLE_LEN; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_deg23(i));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_deg23(i));
      end
    end
    if (x > one) x = one;
    if (x < -one) x = -one;
    if (y > one) y = one;
    if (y < -one) y = -one;
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    if (FRACTION_BITS >= 14) v = round_shift(v, FRACTION_BITS - 14);
    else v = v * (longint'(1) << (14 - FRACTION_BITS));
    if (v > OUT_ONE) v = OUT_ONE;
    if (v < -OUT_ONE) v = -OUT_ONE;
    return v[15:0];
  endfunction

  // Computes the three rows of Ry*Rx*Rz for one angle triple.
  function automatic axes_t predict_axes(logic [16:0] ax, logic [16:0] ay, logic [16:0] az);
    axes_t r;
    longint sx, cx, sy, cy, sz, cz, sysx, cysx;
    trig_of(ax, sx, cx);
    trig_of(ay, sy, cy);
    trig_of(az, sz, cz);
    sysx = fx_mul(sy, sx);
    cysx = fx_mul(cy, sx);
    r.v[0] = to_q14(fx_mul(cy, cz) - fx_mul(sysx, sz));
    r.v[1] = to_q14(fx_mul(cy, sz) + fx_mul(sysx, cz));
    r.v[2] = to_q14(-fx_mul(sy, cx));
    r.v[3] = to_q14(-fx_mul(cx, sz));
    r.v[4] = to_q14(fx_mul(cx, cz));
    r.v[5] = to_q14(sx);
    r.v[6] = to_q14(fx_mul(sy, cz) + fx_mul(cysx, sz));
    r.v[7] = to_q14(fx_mul(sy, sz) - fx_mul(cysx, cz));
    r.v[8] = to_q14(fx_mul(cy, cx));
    return r;
  endfunction

  // Holds the expected axis sets in order and compares each arriving set.
  class axes_scoreboard;
    axes_t pending[$];
    int errors;

    function void note_angles(logic [16:0] ax, logic [16:0] ay, logic [16:0] az);
      pending.push_back(predict_axes(ax, ay, az));
    endfunction

    function void check_axes(axes_t got);
      axes_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected axis set with nothing pending");
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (got.v[k] !== want.v[k]) begin
          errors++;
          if (errors <= 10)
            $display("Component %0d mismatch: expected %0d, got %0d", k, want.v[k], got.v[k]);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  eac_angles_if angles();
  eac_axes_if axes();

  euler_angles_to_axes_core #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS),
    .FRACTION_BITS(FRACTION_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .angles(angles.sink),
    .axes(axes.source)
  );

  always #5 clk = ~clk;

  axes_scoreboard board = new();
  bit calm = 0;      // set near the end of the run: no more idling on either side

  initial begin
    angles.valid = 0;
    angles.angle_x = '0;
    angles.angle_y = '0;
    angles.angle_z = '0;
    axes.ready = 0;
  end

  // Presents one angle triple, then holds it until the core takes it.
  task automatic send_angles(logic [16:0] ax, logic [16:0] ay, logic [16:0] az);
    angles.valid <= 1;
    angles.angle_x <= ax;
    angles.angle_y <= ay;
    angles.angle_z <= az;
    do @(posedge clk); while (!angles.ready);
    board.note_angles(ax, ay, az);
  endtask

  // Optional idle burst between items; valid drops here and once more after the last item.
  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      angles.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [16:0] random_angle();
    case ($urandom_range(0, 5))
      0: return 17'($urandom_range(0, 131071));   // any pattern, including beyond 360
      1: return 17'(int'($urandom_range(0, 8)) * 5760 - 23040 + int'($urandom_range(0, 2)) - 1);
      default: return 17'(int'($urandom_range(0, 92160)) - 46080);
    endcase
  endfunction

  // Result side: random stall bursts, check on every accepted set.
  always @(posedge clk) begin
    axes_t got;
    if (!rst && axes.valid && axes.ready) begin
      got.v[0] = axes.side_x;
      got.v[1] = axes.side_y;
      got.v[2] = axes.side_z;
      got.v[3] = axes.up_x;
      got.v[4] = axes.up_y;
      got.v[5] = axes.up_z;
      got.v[6] = axes.forward_x;
      got.v[7] = axes.forward_y;
      got.v[8] = axes.forward_z;
      board.check_axes(got);
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (rst || calm) begin
        axes.ready <= 1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        axes.ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        axes.ready <= 1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [16:0] corner[$];
    int waited;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: zero, the right angles, half and full turns, the range ends,
    // out-of-range patterns that wrap, and the fold boundaries on both sides.
    corner = '{17'd0, 17'd11520, -17'sd11520, 17'd11521, -17'sd11521,
               17'd23040, -17'sd23040, 17'd23039, 17'd46080, -17'sd46080,
               17'h0FFFF, 17'h10000, 17'h1FFFF, 17'd5760};
    foreach (corner[i]) begin
      send_angles(corner[i], corner[(i + 3) % corner.size()], corner[(i + 7) % corner.size()]);
      maybe_idle();
    end
    send_angles(17'h0FFFF, 17'h10000, 17'h1FFFF);
    send_angles(17'd11520, 17'd11520, 17'd11520);

    // Random part; the last stretch runs without any idling.
    for (int i = 0; i < 1000; i++) begin
      if (i == 850) calm = 1;
      send_angles(random_angle(), random_angle(), random_angle());
      maybe_idle();
    end
    angles.valid <= 0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
